// ===== src/bbl_pkg.sv =====
// ----------------------------------------------------------------------------
// bbl_pkg - shared types and constants of the line box blur
// Sample and field widths, register codes, controller states and the
// command/status groups between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bbl_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int NUM_CH         = 3;
	localparam int PIXEL_W        = NUM_CH * SAMPLE_BITS;
	localparam int RADIUS_W       = 4;
	localparam int SCALE_W        = 17;
	localparam int FRAC_BITS      = 16;
	localparam int MAX_RADIUS_DEF = 15;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SCALE_W;

	localparam logic [RADIUS_W-1:0]    RADIUS_RESET = RADIUS_W'(1);
	localparam logic [SCALE_W-1:0]     SCALE_RESET  = SCALE_W'(21845);
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX   = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RADIUS = 1'b0,
		REG_SCALE  = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN,
		ST_MUL,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic ring_we;
		logic first_we;
		logic rd_en;
		logic use_first;
		logic acc_start;
		logic mul_en;
		logic out_load;
		logic out_line_end;
		logic out_run_last;
	} cmd_t;

	typedef struct packed {
		logic out_full;
	} stat_t;

endpackage

`default_nettype wire

// ===== src/bbl_ram.sv =====
// ----------------------------------------------------------------------------
// bbl_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/bbl_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbl_ctrl - sequencer of the line box blur
// Tracks line position and ring head, walks each output window one tap per
// cycle and steps the datapath through accumulate, multiply and output.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_ctrl
	import bbl_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	localparam int DEPTH = 2 * MAX_RADIUS + 1,
	localparam int AW    = $clog2(DEPTH),
	localparam int LW    = $clog2(DEPTH + 1),
	localparam int DW    = $clog2(MAX_RADIUS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                in_end,
	input  wire logic [RADIUS_W-1:0] radius,
	input  wire stat_t               stat,
	output cmd_t                     cmd,
	output logic      [AW-1:0]       wr_addr,
	output logic      [AW-1:0]       rd_addr
);

	state_t        state_q, state_d;
	logic [LW-1:0] lp_q;
	logic [AW-1:0] head_q;
	logic [DW-1:0] d_q;
	logic [AW-1:0] j_q;
	logic          end_q;

	logic [DW-1:0] r_eff;
	logic [LW-1:0] lp_new;
	logic [AW-1:0] head_next;
	logic [DW-1:0] top_d;
	logic          has_out;
	logic          accept;
	logic          last_j;
	logic [AW-1:0] kk;
	logic          use_first;
	int            lpm1;
	int            k_i;
	int            kk_i;
	int            top_i;

	assign r_eff = (int'(radius) > MAX_RADIUS) ? DW'(MAX_RADIUS) : DW'(radius);
	assign lp_new = (int'(lp_q) < DEPTH) ? lp_q + LW'(1) : lp_q;
	assign head_next = (int'(head_q) == DEPTH - 1) ? '0 : head_q + AW'(1);
	assign wr_addr = head_next;
	assign accept = (state_q == ST_IDLE) && in_valid;
	assign last_j = int'(j_q) == 2 * int'(r_eff);

	// first output distance and whether this pixel yields any output
	always_comb begin
		lpm1 = int'(lp_new) - 1;
		if (in_end) begin
			has_out = 1'b1;
			top_i   = (lpm1 < int'(r_eff)) ? lpm1 : int'(r_eff);
		end else begin
			has_out = lpm1 >= int'(r_eff);
			top_i   = int'(r_eff);
		end
		top_d = DW'(top_i);
	end

	// window tap: offset back from the newest pixel, clamped to the line
	always_comb begin
		k_i       = int'(d_q) - int'(r_eff) + int'(j_q);
		kk_i      = (k_i < 0) ? 0 : k_i;
		kk        = AW'(kk_i);
		use_first = kk_i >= int'(lp_q);
		if (head_q >= kk) begin
			rd_addr = head_q - kk;
		end else begin
			rd_addr = AW'(int'(head_q) + DEPTH - int'(kk));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.ring_we  = 1'b1;
					cmd.first_we = lp_q == '0;
					state_d      = has_out ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.rd_en     = 1'b1;
				cmd.use_first = use_first;
				cmd.acc_start = j_q == '0;
				if (last_j) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (!stat.out_full) begin
					cmd.out_load     = 1'b1;
					cmd.out_line_end = end_q && (d_q == '0);
					cmd.out_run_last = (d_q == '0) || !end_q;
					state_d          = (d_q == '0) ? ST_IDLE : ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q   <= '0;
			head_q <= '0;
			d_q    <= '0;
			j_q    <= '0;
			end_q  <= 1'b0;
		end else begin
			if (accept) begin
				lp_q   <= lp_new;
				head_q <= head_next;
				end_q  <= in_end;
				d_q    <= top_d;
				j_q    <= '0;
			end else if (state_q == ST_READ && !last_j) begin
				j_q <= j_q + AW'(1);
			end else if (cmd.out_load) begin
				j_q <= '0;
				if (d_q == '0) begin
					if (end_q) begin
						lp_q <= '0;
					end
				end else begin
					d_q <= d_q - DW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/bbl_dp.sv =====
// ----------------------------------------------------------------------------
// bbl_dp - datapath of the line box blur
// Pixel ring RAM, first pixel of the line, per-channel window accumulators,
// scale multipliers, rounding with saturation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bbl_dp
	import bbl_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	localparam int DEPTH  = 2 * MAX_RADIUS + 1,
	localparam int AW     = $clog2(DEPTH),
	localparam int SUM_W  = SAMPLE_BITS + $clog2(DEPTH),
	localparam int PROD_W = SUM_W + SCALE_W,
	localparam int RND_W  = PROD_W + 1
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmd_t                   cmd,
	input  wire logic [AW-1:0]          wr_addr,
	input  wire logic [AW-1:0]          rd_addr,
	input  wire logic [PIXEL_W-1:0]     pixel_in,
	input  wire logic [SCALE_W-1:0]     scale,
	output stat_t                       stat,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic      [PIXEL_W-1:0]     out_pixel,
	output logic                        out_line_end,
	output logic                        out_run_last
);

	logic [PIXEL_W-1:0]     ring_rdata;
	logic [PIXEL_W-1:0]     first_q;
	logic [PIXEL_W-1:0]     sample;
	logic                   acc_en_s1;
	logic                   use_first_s1;
	logic                   start_s1;
	logic [SUM_W-1:0]       acc_q  [NUM_CH];
	logic [PROD_W-1:0]      prod_q [NUM_CH];
	logic [PIXEL_W-1:0]     avg;
	logic [RND_W-1:0]       rnd    [NUM_CH];
	logic                   out_valid_q;
	logic [PIXEL_W-1:0]     out_pix_q;
	logic                   out_le_q;
	logic                   out_rl_q;

	bbl_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (cmd.ring_we),
		.waddr (wr_addr),
		.wdata (pixel_in),
		.re    (cmd.rd_en),
		.raddr (rd_addr),
		.rdata (ring_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.first_we) begin
			first_q <= pixel_in;
		end
	end

	// tap flags are registered alongside the RAM read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1    <= 1'b0;
			use_first_s1 <= 1'b0;
			start_s1     <= 1'b0;
		end else begin
			acc_en_s1    <= cmd.rd_en;
			use_first_s1 <= cmd.use_first;
			start_s1     <= cmd.acc_start;
		end
	end

	assign sample = use_first_s1 ? first_q : ring_rdata;

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CH; c++) begin
			if (acc_en_s1) begin
				acc_q[c] <= (start_s1 ? '0 : acc_q[c])
					+ SUM_W'(sample[c*SAMPLE_BITS +: SAMPLE_BITS]);
			end
			if (cmd.mul_en) begin
				prod_q[c] <= PROD_W'(acc_q[c]) * PROD_W'(scale);
			end
		end
	end

	// round half up at the Q16 point, then clamp to the sample range
	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			rnd[c] = ({1'b0, prod_q[c]} + RND_W'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
			if (|rnd[c][RND_W-1:SAMPLE_BITS]) begin
				avg[c*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_MAX;
			end else begin
				avg[c*SAMPLE_BITS +: SAMPLE_BITS] = rnd[c][SAMPLE_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_pix_q <= avg;
			out_le_q  <= cmd.out_line_end;
			out_rl_q  <= cmd.out_run_last;
		end
	end

	assign stat.out_full = out_valid_q && !out_ready;
	assign out_valid     = out_valid_q;
	assign out_pixel     = out_pix_q;
	assign out_line_end  = out_le_q;
	assign out_run_last  = out_rl_q;

endmodule

`default_nettype wire

// ===== src/box_blur_line_clamp_edge_unit.sv =====
// ----------------------------------------------------------------------------
// box_blur_line_clamp_edge_unit - horizontal box blur of one RGB line
// Edge-replicating box average over 2*radius+1 pixels, one pixel in and
// a run of averaged pixels out, with a small register write port.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: red, green, blue; tlast: line end
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: red, green, blue; tlast: line end;
//                                                tuser: last result of a line-end run (high on other pixels' results)
//  cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data (0 radius, 1 scale)
//
//  Each output pixel is built in steps: 2r+1 single-tap reads of the pixel
//  ring RAM, one accumulate drain, one multiply, one output load.
//  A pixel before the line end yields 0 or r+1 outputs, and the line's last
//  pixel yields up to r+1 drain outputs.
//  The next pixel is taken while the last result still sits in the output
//  register; a stalled m_axis holds the sequencer before the next load.
//  No clearing pass after reset; ring entries are read only once written.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_line_clamp_edge_unit
	import bbl_pkg::*;
#(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	localparam int DEPTH = 2 * MAX_RADIUS + 1,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [PIXEL_W-1:0]    s_axis_tdata,   // in_red, in_green, in_blue
	input  wire logic                  s_axis_tlast,   // in_line_end

	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic      [PIXEL_W-1:0]    m_axis_tdata,   // out_red, out_green, out_blue
	output logic                       m_axis_tlast,   // out_line_end
	output logic      [0:0]            m_axis_tuser,   // run_last

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [RADIUS_W-1:0] radius_q;
	logic [SCALE_W-1:0]  scale_q;
	cmd_t                cmd;
	stat_t               stat;
	logic [AW-1:0]       wr_addr;
	logic [AW-1:0]       rd_addr;
	logic                run_last;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			scale_q  <= SCALE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_RADIUS: radius_q <= cfg_data[RADIUS_W-1:0];
				REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				default:    ;
			endcase
		end
	end

	bbl_ctrl #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_end   (s_axis_tlast),
		.radius   (radius_q),
		.stat     (stat),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	bbl_dp #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.pixel_in     (s_axis_tdata),
		.scale        (scale_q),
		.stat         (stat),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_pixel    (m_axis_tdata),
		.out_line_end (m_axis_tlast),
		.out_run_last (run_last)
	);

	assign m_axis_tuser = run_last;

endmodule

`default_nettype wire

// ===== verif/box_blur_line_clamp_edge_unit_test.sv =====
// ----------------------------------------------------------------------------
// box_blur_line_clamp_edge_unit_test - line box blur regression
// Streams RGB lines into the blur, predicts every averaged pixel with an
// in-bench running model of the edge-clamped window, and checks each output
// transfer in order. Directed lines cover edges, short lines and register
// extremes; random phases vary radius, scale, line length and idling.
// ----------------------------------------------------------------------------
`default_nettype none

module box_blur_line_clamp_edge_unit_test;
	import bbl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RING_DEPTH   = 2 * MAX_RADIUS_DEF + 1;
	localparam int PX_CYCLES    = 2 * MAX_RADIUS_DEF + 4;
	localparam int DRAIN_CYCLES = 2 * PX_CYCLES;
	localparam int END_CYCLES   = 4 * PX_CYCLES;
	localparam int RANDOM_ITEMS = 370;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int MAX_REPORTS  = 10;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] blue;
		logic [SAMPLE_BITS-1:0] green;
		logic [SAMPLE_BITS-1:0] red;
		logic                   line_end;
		logic                   run_last;
	} blur_px_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [PIXEL_W-1:0]    s_axis_tdata;   // in_red, in_green, in_blue
	logic                  s_axis_tlast;   // in_line_end

	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [PIXEL_W-1:0]    m_axis_tdata;   // out_red, out_green, out_blue
	logic                  m_axis_tlast;   // out_line_end
	logic [0:0]            m_axis_tuser;   // run_last

	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	box_blur_line_clamp_edge_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// blur model state
	logic [PIXEL_W-1:0]  ring_px [RING_DEPTH];
	logic [PIXEL_W-1:0]  line_head;
	int                  line_fill;
	logic [RADIUS_W-1:0] radius_cur;
	logic [SCALE_W-1:0]  scale_cur;

	blur_px_t pending_px [$];

	int unsigned cycle_count   = 0;
	int          errors        = 0;
	int          items_sent    = 0;
	int          results_seen  = 0;
	int          lines_sent    = 0;
	int          phases_run    = 0;
	logic [15:0] radii_used    = '0;
	int          tx_idle_pct   = 30;
	int          rx_idle_pct   = 30;

	function automatic int idle_gap(input int pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 50);
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] rand_sample();
		case ($urandom_range(19))
			0:       return '0;
			1:       return '1;
			default: return SAMPLE_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [PIXEL_W-1:0] rgb(input logic [SAMPLE_BITS-1:0] r,
			input logic [SAMPLE_BITS-1:0] g, input logic [SAMPLE_BITS-1:0] b);
		return {b, g, r};
	endfunction

	function automatic logic [PIXEL_W-1:0] rand_pixel();
		return rgb(rand_sample(), rand_sample(), rand_sample());
	endfunction

	// past the line end -> newest pixel; before the line start -> first pixel
	function automatic logic [PIXEL_W-1:0] tap(input int k);
		int kk;
		kk = (k < 0) ? 0 : k;
		if (kk >= line_fill)
			return line_head;
		return ring_px[kk];
	endfunction

	function automatic logic [SAMPLE_BITS-1:0] box_avg(input logic [63:0] sum);
		logic [63:0] v;
		v = (sum * 64'(scale_cur) + 64'd32768) >> FRAC_BITS;
		return (v > 64'(SAMPLE_MAX)) ? SAMPLE_MAX : v[SAMPLE_BITS-1:0];
	endfunction

	task automatic blur_reset();
		radius_cur = RADIUS_RESET;
		scale_cur  = SCALE_RESET;
		line_head  = '0;
		line_fill  = 0;
	endtask

	task automatic predict_blur(input logic [PIXEL_W-1:0] px, input logic line_end);
		int          r, top, d, k;
		logic [63:0] acc_r, acc_g, acc_b;
		logic [PIXEL_W-1:0] t;
		blur_px_t    res;
		if (line_fill == 0)
			line_head = px;
		for (k = RING_DEPTH - 1; k > 0; k--)
			ring_px[k] = ring_px[k-1];
		ring_px[0] = px;
		if (line_fill < RING_DEPTH)
			line_fill++;
		r = int'(radius_cur);
		if (line_end)
			top = (r < line_fill - 1) ? r : line_fill - 1;
		else
			top = (line_fill - 1 >= r) ? r : -1;
		for (d = top; d >= 0; d--) begin
			acc_r = '0;
			acc_g = '0;
			acc_b = '0;
			for (k = d - r; k <= d + r; k++) begin
				t = tap(k);
				acc_r += 64'(t[0 +: SAMPLE_BITS]);
				acc_g += 64'(t[SAMPLE_BITS +: SAMPLE_BITS]);
				acc_b += 64'(t[2*SAMPLE_BITS +: SAMPLE_BITS]);
			end
			res.red      = box_avg(acc_r);
			res.green    = box_avg(acc_g);
			res.blue     = box_avg(acc_b);
			res.line_end = line_end && (d == 0);
			res.run_last = (d == 0) || !line_end;
			pending_px.push_back(res);
		end
		if (line_end) begin
			line_fill = 0;
			lines_sent++;
		end
	endtask

	task automatic send_pixel(input logic [PIXEL_W-1:0] px, input logic line_end);
		int gap;
		gap = idle_gap(tx_idle_pct);
		@(negedge clk);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		s_axis_tlast  <= line_end;
		do
			@(posedge clk);
		while (!s_axis_tready);
		predict_blur(px, line_end);
		items_sent++;
	endtask

	task automatic send_line(input logic [PIXEL_W-1:0] px [$]);
		foreach (px[i])
			send_pixel(px[i], i == px.size() - 1);
	endtask

	task automatic wait_for_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_px.size() != 0)
			@(posedge clk);
	endtask

	// a pixel with no output may still be in the ring write when the queue empties
	task automatic wait_idle();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			REG_RADIUS: begin
				radius_cur = value[RADIUS_W-1:0];
				radii_used[radius_cur] = 1'b1;
			end
			REG_SCALE:  scale_cur = value[SCALE_W-1:0];
			default:    ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_window(input int r, input int unsigned sc);
		wait_idle();
		write_reg(REG_RADIUS, CFG_DATA_W'(r));
		write_reg(REG_SCALE, CFG_DATA_W'(sc));
	endtask

	// reset values: radius 1, scale 1/3; single, two and four pixel lines
	task automatic test_reset_window();
		send_line('{rgb('1, '1, '1)});
		send_line('{rgb('0, '0, '0), rgb('1, '0, '1)});
		send_line('{rgb(16'h1234, '1, '0), rgb('0, 16'h8000, '1),
			rgb('1, 16'h0001, 16'h7FFF), rgb(16'hAAAA, 16'h5555, '0)});
	endtask

	// identity window, then a zero scale that forces all outputs to zero
	task automatic test_identity_and_zero_scale();
		set_window(0, 65536);
		send_line('{rand_pixel(), rgb('1, '0, 16'h00FF), rand_pixel()});
		set_window(3, 0);
		send_line('{rgb('1, '1, '1), rand_pixel(), rand_pixel(), rgb('1, '1, '1)});
	endtask

	// widest window on a short line, scale above unity saturates
	task automatic test_wide_window();
		set_window(MAX_RADIUS_DEF, (1 << SCALE_W) - 1);
		send_line('{rgb('1, 16'h0100, '0), rgb('1, 16'h0001, '1), rgb('1, '0, 16'h0800)});
	endtask

	task automatic test_radius_change_mid_line();
		set_window(2, 13107);
		send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b0);
		set_window(4, 7282);
		send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b0);
		send_pixel(rand_pixel(), 1'b1);
	endtask

	task automatic test_random_lines();
		int start, r, max_len, len, lines, n;
		int unsigned sc;
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			case ($urandom_range(9))
				0:       r = 0;
				1:       r = MAX_RADIUS_DEF;
				2:       r = $urandom_range(MAX_RADIUS_DEF);
				default: r = $urandom_range(1, 4);
			endcase
			case ($urandom_range(7))
				0:       sc = 0;
				1:       sc = (1 << SCALE_W) - 1;
				2:       sc = $urandom_range((1 << SCALE_W) - 1);
				3:       sc = 65536;
				default: sc = (65536 + r) / (2 * r + 1);
			endcase
			set_window(r, sc);
			tx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 60);
			rx_idle_pct = ($urandom_range(2) == 0) ? 0 : $urandom_range(10, 60);
			max_len = (r == MAX_RADIUS_DEF) ? 20 : 40;
			if ($urandom_range(3) == 0) begin
				// free-running stream: ends fall anywhere, phase may stop mid-line
				n = $urandom_range(8, 30);
				repeat (n)
					send_pixel(rand_pixel(), $urandom_range(5) == 0);
			end else begin
				lines = $urandom_range(1, 3);
				for (int l = 0; l < lines; l++) begin
					len = ($urandom_range(4) == 0) ? $urandom_range(1, 3)
						: $urandom_range(1, max_len);
					for (int i = 0; i < len; i++)
						send_pixel(rand_pixel(), i == len - 1);
					if (l == 0 && phases_run % 3 == 1)
						wait_for_results();
				end
			end
			phases_run++;
		end
	endtask

	initial begin : rx_side
		int hold;
		hold = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
			end else begin
				hold = idle_gap(rx_idle_pct);
				if (hold > 0) begin
					m_axis_tready <= 1'b0;
					hold--;
				end else begin
					m_axis_tready <= 1'b1;
					hold = $urandom_range(0, 6);
				end
			end
		end
	end

	always @(posedge clk) begin
		blur_px_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.red      = m_axis_tdata[0 +: SAMPLE_BITS];
			got.green    = m_axis_tdata[SAMPLE_BITS +: SAMPLE_BITS];
			got.blue     = m_axis_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
			got.line_end = m_axis_tlast;
			got.run_last = m_axis_tuser[0];
			if (pending_px.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected output transfer: r=%h g=%h b=%h end=%b last=%b",
						got.red, got.green, got.blue, got.line_end, got.run_last);
			end else begin
				want = pending_px.pop_front();
				if (got !== want) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display({"mismatch at output %0d: exp r=%h g=%h b=%h end=%b last=%b",
							" / got r=%h g=%h b=%h end=%b last=%b"}, results_seen,
							want.red, want.green, want.blue, want.line_end, want.run_last,
							got.red, got.green, got.blue, got.line_end, got.run_last);
				end
			end
			results_seen++;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d outputs outstanding",
				cycle_count, pending_px.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_RADIUS;
		cfg_data      = '0;
		blur_reset();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_window();
		test_identity_and_zero_scale();
		test_wide_window();
		test_radius_change_mid_line();
		test_random_lines();

		wait_for_results();
		repeat (END_CYCLES) @(posedge clk);
		if (pending_px.size() != 0) begin
			errors += pending_px.size();
			$display("%0d expected outputs never arrived", pending_px.size());
		end
		$display("covered %0d pixels in %0d lines, %0d outputs, %0d random phases",
			items_sent, lines_sent, results_seen, phases_run);
		$display("radius values used (bit per radius): %b, mismatches: %0d",
			radii_used, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
